[sv/tbps_pkg.sv]
`timescale 1ns / 1ps
// Shared types, codes and reset values of the token bucket packet shaper.
package tbps_pkg;

  localparam int unsigned QueueDepthDef = 64;

  localparam int unsigned IdW     = 32;
  localparam int unsigned NeedW   = 16;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CountOutW = 7;

  localparam logic [NeedW-1:0] BucketDepthRst = 16'd10;
  localparam logic [NeedW-1:0] FixedNeedRst   = 16'd3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgBucketDepth = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgFixedNeed   = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgNeedSource  = 2'd2;

  // event kinds
  localparam logic OpTokenTick = 1'b0;
  localparam logic OpArrival   = 1'b1;

  // result status codes
  localparam logic [StatusW-1:0] StTokenAdded   = 3'd0;
  localparam logic [StatusW-1:0] StTokenDropped = 3'd1;
  localparam logic [StatusW-1:0] StQueued       = 3'd2;
  localparam logic [StatusW-1:0] StTooBig       = 3'd3;
  localparam logic [StatusW-1:0] StQueueFull    = 3'd4;

  typedef struct packed {
    logic [IdW-1:0]   id;
    logic [NeedW-1:0] need;
  } tbps_entry_t;

  typedef struct packed {
    logic load;   // take the new packet
    logic shift;  // take the neighbor's packet
  } tbps_cell_ctrl_t;

endpackage

[sv/tbps_cell.sv]
`timescale 1ns / 1ps
// One waiting-queue cell: holds a packet, loads a new one or takes its neighbor's.
module tbps_cell
  import tbps_pkg::*;
(
  input  logic            clk_i,
  input  tbps_cell_ctrl_t ctrl_i,
  input  tbps_entry_t     new_i,
  input  tbps_entry_t     next_i,
  output tbps_entry_t     entry_o
);

  tbps_entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = new_i;
    end else if (ctrl_i.shift) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

[sv/tbps_chain.sv]
`timescale 1ns / 1ps
// Row of queue cells: head in cell 0, pop shifts every cell toward the head.
module tbps_chain
  import tbps_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef,
  parameter int unsigned CntW       = $clog2(QueueDepth + 1)
) (
  input  logic            clk_i,
  input  logic            push_i,
  input  logic [CntW-1:0] fill_i,   // packets stored now; push lands here
  input  logic            pop_i,
  input  tbps_entry_t     new_i,
  output tbps_entry_t     head_o
);

  tbps_entry_t cells [QueueDepth];

  for (genvar i = 0; i < QueueDepth; i++) begin : g_cell
    tbps_cell_ctrl_t ctrl;
    tbps_entry_t     next;

    assign ctrl.load  = push_i && (fill_i == CntW'(i));
    assign ctrl.shift = pop_i;

    if (i == QueueDepth - 1) begin : g_last
      assign next = cells[i];
    end else begin : g_mid
      assign next = cells[i+1];
    end

    tbps_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl),
      .new_i   (new_i),
      .next_i  (next),
      .entry_o (cells[i])
    );
  end

  assign head_o = cells[0];

endmodule

[sv/token_bucket_packet_shaper_unit.sv]
`timescale 1ns / 1ps
// Top level of the token bucket packet shaper with its waiting queue.
//
// channel   direction  handshake                     payload
// s_axis    in         s_axis_tvalid/s_axis_tready   tuser op, tdata packet_need
// m_axis    out        m_axis_tvalid/m_axis_tready   tuser status+released, tdata rest
// cfg       in         cfg_valid_i/cfg_ready_o       cfg_index_i, cfg_data_i
//
// One item per cycle while m_axis_tready holds: bucket update, head check and queue
// push or pop finish in the cycle the item is taken; the result is then registered.
// The input is taken whenever the output register is empty or is drained that cycle.
// Reset clears the bucket, the id counter, the fill count and the output valid flag;
// the queue cells hold no reset and are read only after being written.
// Configuration writes are always taken.
module token_bucket_packet_shaper_unit
  import tbps_pkg::*;
#(
  parameter int unsigned QueueDepth = QueueDepthDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,

  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [15:0]         s_axis_tdata,   // [15:0] packet_need
  input  logic [0:0]          s_axis_tuser,   // [0] op

  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [103:0]        m_axis_tdata,   // [31:0] arrival_id, [63:32] released_id,
                                              // [79:64] released_need,
                                              // [95:80] bucket_level,
                                              // [102:96] queue_count, [103] zero
  output logic [3:0]          m_axis_tuser,   // [2:0] status, [3] released

  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [NeedW-1:0]    cfg_data_i
);

  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  // configuration
  logic [NeedW-1:0] depth_q, depth_d;
  logic [NeedW-1:0] fixed_q, fixed_d;
  logic             src_q, src_d;

  // shaper state
  logic [NeedW-1:0] level_q, level_d;
  logic [IdW-1:0]   ctr_q, ctr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  // result register
  logic                 ovalid_q, ovalid_d;
  logic [StatusW-1:0]   ostatus_q, ostatus_d;
  logic [IdW-1:0]       oaid_q, oaid_d;
  logic                 orel_q, orel_d;
  logic [IdW-1:0]       orid_q, orid_d;
  logic [NeedW-1:0]     orneed_q, orneed_d;
  logic [NeedW-1:0]     olevel_q, olevel_d;
  logic [CountOutW-1:0] ocnt_q, ocnt_d;

  logic            accept;
  logic            op;
  logic [NeedW-1:0] need;
  logic            push, pop, release_ok, check, too_big, full;
  logic [CntW-1:0] cnt_push;
  logic [NeedW-1:0] level_pre;
  logic [IdW-1:0]  aid;
  logic [StatusW-1:0] status;
  tbps_entry_t     new_entry, head, cand;
  logic [CntW+CountOutW-1:0] cnt_ext;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !ovalid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    depth_d = depth_q;
    fixed_d = fixed_q;
    src_d   = src_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgBucketDepth: depth_d = cfg_data_i;
        CfgFixedNeed:   fixed_d = cfg_data_i;
        CfgNeedSource:  src_d   = cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign op   = s_axis_tuser[0];
  assign need = src_q ? s_axis_tdata : fixed_q;
  assign new_entry.id   = ctr_q + IdW'(1);
  assign new_entry.need = need;

  always_comb begin
    push      = 1'b0;
    check     = 1'b0;
    too_big   = 1'b0;
    full      = 1'b0;
    aid       = '0;
    level_pre = level_q;
    cand      = head;
    status    = StTokenAdded;
    if (op == OpTokenTick) begin
      if (level_q < depth_q) begin
        level_pre = level_q + NeedW'(1);
        status    = StTokenAdded;
      end else begin
        status    = StTokenDropped;
      end
      check = (cnt_q != '0);
    end else begin
      aid     = new_entry.id;
      too_big = need > depth_q;
      full    = cnt_q == CntW'(QueueDepth);
      if (too_big) begin
        status = StTooBig;
      end else if (full) begin
        status = StQueueFull;
      end else begin
        status = StQueued;
        push   = 1'b1;
      end
      // an empty queue makes the new packet the head at once
      if (cnt_q == '0) begin
        cand = new_entry;
      end
    end
  end

  assign cnt_push = cnt_q + CntW'(push);

  assign release_ok = (op == OpTokenTick ? check : (cnt_push == CntW'(1)))
                      && (cand.need <= level_pre);

  // a packet released in the cycle it arrives is never stored
  assign pop = accept && release_ok && !(op == OpArrival && cnt_q == '0);

  tbps_chain #(
    .QueueDepth (QueueDepth),
    .CntW       (CntW)
  ) u_chain (
    .clk_i  (clk_i),
    .push_i (accept && push && !(release_ok && cnt_q == '0)),
    .fill_i (cnt_q),
    .pop_i  (pop),
    .new_i  (new_entry),
    .head_o (head)
  );

  always_comb begin
    level_d   = level_q;
    ctr_d     = ctr_q;
    cnt_d     = cnt_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    ostatus_d = ostatus_q;
    oaid_d    = oaid_q;
    orel_d    = orel_q;
    orid_d    = orid_q;
    orneed_d  = orneed_q;
    olevel_d  = olevel_q;
    ocnt_d    = ocnt_q;
    cnt_ext   = '0;
    if (accept) begin
      level_d = release_ok ? level_pre - cand.need : level_pre;
      cnt_d   = cnt_push - CntW'(release_ok);
      if (op == OpArrival) begin
        ctr_d = new_entry.id;
      end
      cnt_ext   = {{CountOutW{1'b0}}, cnt_d};
      ovalid_d  = 1'b1;
      ostatus_d = status;
      oaid_d    = aid;
      orel_d    = release_ok;
      orid_d    = release_ok ? cand.id : '0;
      orneed_d  = release_ok ? cand.need : '0;
      olevel_d  = level_d;
      ocnt_d    = cnt_ext[CountOutW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth_q  <= BucketDepthRst;
      fixed_q  <= FixedNeedRst;
      src_q    <= 1'b0;
      level_q  <= '0;
      ctr_q    <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      depth_q  <= depth_d;
      fixed_q  <= fixed_d;
      src_q    <= src_d;
      level_q  <= level_d;
      ctr_q    <= ctr_d;
      cnt_q    <= cnt_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ostatus_q <= ostatus_d;
    oaid_q    <= oaid_d;
    orel_q    <= orel_d;
    orid_q    <= orid_d;
    orneed_q  <= orneed_d;
    olevel_q  <= olevel_d;
    ocnt_q    <= ocnt_d;
  end

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tuser  = {orel_q, ostatus_q};
  assign m_axis_tdata  = {1'b0, ocnt_q, olevel_q, orneed_q, orid_q, oaid_q};

`ifndef SYNTH
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(QueueDepth))
    else $error("fill count above queue depth");

  a_no_rel_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovalid_q && !orel_q |-> (orid_q == '0) && (orneed_q == '0))
    else $error("release fields set without a release");

  a_id_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op == OpArrival |=> ctr_q == $past(ctr_q) + IdW'(1))
    else $error("arrival id did not advance by one");

  a_tick_no_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op == OpTokenTick |=> cnt_q <= $past(cnt_q))
    else $error("token tick grew the queue");

  a_full_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && op == OpArrival && !too_big && cnt_q == CntW'(QueueDepth)
    |=> ostatus_q == StQueueFull)
    else $error("full queue not reported");
`endif

endmodule
